// ===== src/tclq_pkg.sv =====
// Shared codes and types of the three-class linked queue manager.
`default_nettype none

package tclq_pkg;

    // Request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_HDL = 2'd3;

    // Priority classes
    localparam logic [1:0] CLASS_LOW    = 2'd0;
    localparam logic [1:0] CLASS_NORMAL = 2'd1;
    localparam logic [1:0] CLASS_HIGH   = 2'd2;
    localparam int         NUM_CLASSES  = 3;

    // Field write enables of the entry pool memory
    typedef struct packed {
        logic live_we;
        logic data_we;
        logic next_we;
        logic prev_we;
    } tclq_wr_t;

endpackage

`default_nettype wire

// ===== src/tclq_pool_mem.sv =====
// Entry pool memory: per-entry live flag, class, address, payload and links.
`default_nettype none

module tclq_pool_mem
    import tclq_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire tclq_wr_t         wr,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic             wr_live,
    input  wire logic [1:0]       wr_class,
    input  wire logic [15:0]      wr_address,
    input  wire logic [31:0]      wr_payload,
    input  wire logic [IDX_W-1:0] wr_next,
    input  wire logic [IDX_W-1:0] wr_prev,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic                  rd_live,
    output logic [1:0]            rd_class,
    output logic [15:0]           rd_address,
    output logic [31:0]           rd_payload,
    output logic [IDX_W-1:0]      rd_next,
    output logic [IDX_W-1:0]      rd_prev
);

    logic             live_mem    [DEPTH];
    logic [1:0]       class_mem   [DEPTH];
    logic [15:0]      address_mem [DEPTH];
    logic [31:0]      payload_mem [DEPTH];
    logic [IDX_W-1:0] next_mem    [DEPTH];
    logic [IDX_W-1:0] prev_mem    [DEPTH];

    // Write the enabled fields of one entry
    always_ff @(posedge clk)
    begin
        if (wr.live_we)
        begin
            live_mem[wr_addr] <= wr_live;
        end
        if (wr.data_we)
        begin
            class_mem[wr_addr]   <= wr_class;
            address_mem[wr_addr] <= wr_address;
            payload_mem[wr_addr] <= wr_payload;
        end
        if (wr.next_we)
        begin
            next_mem[wr_addr] <= wr_next;
        end
        if (wr.prev_we)
        begin
            prev_mem[wr_addr] <= wr_prev;
        end
    end

    // Read one whole entry, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_live    <= live_mem[rd_addr];
            rd_class   <= class_mem[rd_addr];
            rd_address <= address_mem[rd_addr];
            rd_payload <= payload_mem[rd_addr];
            rd_next    <= next_mem[rd_addr];
            rd_prev    <= prev_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/three_class_linked_queue_manager.sv =====
// Three-class linked queue manager: sequencer, free stack and queue registers.
//
// Requests enter on in_valid/in_ready (push, pop oldest of a class, remove by
// handle); each produces exactly one result on out_valid/out_ready.
// The three FIFO queues are doubly linked lists kept in the entry pool memory;
// free entries sit in a free stack memory. Both memories have one write port
// and a registered read, so every request runs as a short sequence of states,
// ending when the result is loaded:
//   - refused or no-op requests: reply only
//   - push: free stack read, entry write, link from old tail (non-empty class)
//   - pop / remove: entry read and unlink, then one write per neighbor link rewritten
// One request is in work at a time; the next is accepted the cycle after the
// result is loaded.
// After reset a clearing pass over all POOL_ENTRIES entries fills the free stack and
// clears the live flags; in_ready stays low during it.
// A result waits in the output register while the receiver stalls; a new
// request is still accepted, and its result is held until the output is free.
`default_nettype none

module three_class_linked_queue_manager
    import tclq_pkg::*;
#(
    parameter int POOL_ENTRIES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [1:0]  priority_req,
    input  wire logic [15:0] address,
    input  wire logic [31:0] payload,
    input  wire logic [5:0]  handle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [5:0]       entry_handle,
    output logic [15:0]      entry_address,
    output logic [31:0]      entry_payload,
    output logic [1:0]       entry_class,
    output logic [6:0]       class_count
);

    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CW    = $clog2(POOL_ENTRIES + 1);
    localparam int EW    = (CW > 6) ? CW : 6;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_PUSH  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_FIXN  = 7'b0010000,
        S_FIXP  = 7'b0100000,
        S_REPLY = 7'b1000000
    } state_t;

    // Control registers
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] init_cnt_reg, init_cnt_next;
    logic [CW-1:0]    free_top_reg, free_top_next;
    logic [IDX_W-1:0] head_reg [NUM_CLASSES];
    logic [IDX_W-1:0] head_next [NUM_CLASSES];
    logic [IDX_W-1:0] tail_reg [NUM_CLASSES];
    logic [IDX_W-1:0] tail_next [NUM_CLASSES];
    logic [CW-1:0]    size_reg [NUM_CLASSES];
    logic [CW-1:0]    size_next [NUM_CLASSES];
    logic             do_fixn_reg, do_fixn_next;
    logic             do_fixp_reg, do_fixp_next;
    logic             out_valid_reg, out_valid_next;

    // Request and work payload registers
    logic [1:0]       op_reg, op_next;
    logic [1:0]       cls_reg, cls_next;
    logic [15:0]      addr_reg, addr_next;
    logic [31:0]      pay_reg, pay_next;
    logic [IDX_W-1:0] e_reg, e_next;
    logic [IDX_W-1:0] fixn_addr_reg, fixn_addr_next;
    logic [IDX_W-1:0] fixn_data_reg, fixn_data_next;
    logic [IDX_W-1:0] fixp_addr_reg, fixp_addr_next;
    logic [IDX_W-1:0] fixp_data_reg, fixp_data_next;

    // Staged result and output registers
    logic [1:0]       res_status_reg, res_status_next;
    logic [5:0]       res_handle_reg, res_handle_next;
    logic [15:0]      res_address_reg, res_address_next;
    logic [31:0]      res_payload_reg, res_payload_next;
    logic [1:0]       res_class_reg, res_class_next;
    logic [6:0]       res_count_reg, res_count_next;
    logic [1:0]       status_reg, status_next;
    logic [5:0]       handle_out_reg, handle_out_next;
    logic [15:0]      address_out_reg, address_out_next;
    logic [31:0]      payload_out_reg, payload_out_next;
    logic [1:0]       class_out_reg, class_out_next;
    logic [6:0]       count_out_reg, count_out_next;

    // Free stack memory
    logic [IDX_W-1:0] free_mem [POOL_ENTRIES];
    logic [IDX_W-1:0] fs_rdata_reg;
    logic             fs_we, fs_re;
    logic [IDX_W-1:0] fs_waddr, fs_wdata, fs_raddr;

    // Pool memory ports
    tclq_wr_t         pool_wr;
    logic [IDX_W-1:0] pool_waddr;
    logic             pool_wlive;
    logic [IDX_W-1:0] pool_wnext, pool_wprev;
    logic             pool_re;
    logic [IDX_W-1:0] pool_raddr;
    logic             pool_rd_live;
    logic [1:0]       pool_rd_class;
    logic [15:0]      pool_rd_address;
    logic [31:0]      pool_rd_payload;
    logic [IDX_W-1:0] pool_rd_next, pool_rd_prev;

    // Request decode helpers
    logic             accept;
    logic             in_cls_ok;
    logic [1:0]       in_ci;
    logic [EW-1:0]    handle_ext;
    logic             handle_ok;
    logic [IDX_W-1:0] handle_idx;
    logic [1:0]       ev_cls;
    logic [CW-1:0]    ev_size;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign in_cls_ok  = (priority_req < NUM_CLASSES);
    assign in_ci      = in_cls_ok ? priority_req : CLASS_LOW;
    assign handle_ext = EW'(handle);
    assign handle_ok  = (handle_ext < EW'(POOL_ENTRIES));
    assign handle_idx = IDX_W'(handle);

    // Class of the entry read back, and its size after the unlink
    assign ev_cls  = (pool_rd_class < NUM_CLASSES) ? pool_rd_class : CLASS_LOW;
    assign ev_size = (size_reg[ev_cls] != '0) ? size_reg[ev_cls] - 1'b1 : '0;

    tclq_pool_mem #(
        .DEPTH (POOL_ENTRIES)
    ) u_pool (
        .clk        (clk),
        .wr         (pool_wr),
        .wr_addr    (pool_waddr),
        .wr_live    (pool_wlive),
        .wr_class   (cls_reg),
        .wr_address (addr_reg),
        .wr_payload (pay_reg),
        .wr_next    (pool_wnext),
        .wr_prev    (pool_wprev),
        .rd_en      (pool_re),
        .rd_addr    (pool_raddr),
        .rd_live    (pool_rd_live),
        .rd_class   (pool_rd_class),
        .rd_address (pool_rd_address),
        .rd_payload (pool_rd_payload),
        .rd_next    (pool_rd_next),
        .rd_prev    (pool_rd_prev)
    );

    // Sequence one request through reads, link rewrites and the reply
    always_comb
    begin
        state_next       = state_reg;
        init_cnt_next    = init_cnt_reg;
        free_top_next    = free_top_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        size_next        = size_reg;
        do_fixn_next     = do_fixn_reg;
        do_fixp_next     = do_fixp_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        cls_next         = cls_reg;
        addr_next        = addr_reg;
        pay_next         = pay_reg;
        e_next           = e_reg;
        fixn_addr_next   = fixn_addr_reg;
        fixn_data_next   = fixn_data_reg;
        fixp_addr_next   = fixp_addr_reg;
        fixp_data_next   = fixp_data_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        res_address_next = res_address_reg;
        res_payload_next = res_payload_reg;
        res_class_next   = res_class_reg;
        res_count_next   = res_count_reg;
        status_next      = status_reg;
        handle_out_next  = handle_out_reg;
        address_out_next = address_out_reg;
        payload_out_next = payload_out_reg;
        class_out_next   = class_out_reg;
        count_out_next   = count_out_reg;

        fs_we      = 1'b0;
        fs_waddr   = init_cnt_reg;
        fs_wdata   = '0;
        fs_re      = 1'b0;
        fs_raddr   = IDX_W'(free_top_reg - 1'b1);
        pool_wr    = '0;
        pool_waddr = e_reg;
        pool_wlive = 1'b0;
        pool_wnext = '0;
        pool_wprev = '0;
        pool_re    = 1'b0;
        pool_raddr = (req_type == REQ_POP) ? head_reg[in_ci] : handle_idx;

        // Drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                pool_wr.live_we = 1'b1;
                pool_waddr      = init_cnt_reg;
                fs_we           = 1'b1;
                fs_wdata        = IDX_W'(POOL_ENTRIES - 1) - init_cnt_reg;
                if (init_cnt_reg == IDX_W'(POOL_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = req_type;
                    cls_next         = priority_req;
                    addr_next        = address;
                    pay_next         = payload;
                    res_status_next  = ST_OK;
                    res_handle_next  = '0;
                    res_address_next = '0;
                    res_payload_next = '0;
                    res_class_next   = priority_req;
                    res_count_next   = '0;
                    state_next       = S_REPLY;
                    case (req_type)
                        REQ_PUSH:
                        begin
                            if (!in_cls_ok)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (free_top_reg == '0)
                            begin
                                res_status_next = ST_FULL;
                                res_count_next  = 7'(size_reg[in_ci]);
                            end
                            else
                            begin
                                fs_re      = 1'b1;
                                state_next = S_PUSH;
                            end
                        end
                        REQ_POP:
                        begin
                            if (!in_cls_ok || size_reg[in_ci] == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                pool_re    = 1'b1;
                                e_next     = head_reg[in_ci];
                                state_next = S_EVAL;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            res_class_next = CLASS_LOW;
                            if (!handle_ok)
                            begin
                                res_status_next = ST_BAD_HDL;
                                res_handle_next = handle;
                            end
                            else
                            begin
                                pool_re    = 1'b1;
                                e_next     = handle_idx;
                                state_next = S_EVAL;
                            end
                        end
                        default:
                        begin
                            res_class_next = CLASS_LOW;
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                // Write the new entry and append it at the tail of its class
                e_next          = fs_rdata_reg;
                pool_wr         = '{live_we: 1'b1, data_we: 1'b1, next_we: 1'b1,
                                    prev_we: 1'b1};
                pool_waddr      = fs_rdata_reg;
                pool_wlive      = 1'b1;
                pool_wnext      = '0;
                pool_wprev      = (size_reg[cls_reg] == '0) ? '0 : tail_reg[cls_reg];
                free_top_next   = free_top_reg - 1'b1;
                if (size_reg[cls_reg] == '0)
                begin
                    head_next[cls_reg] = fs_rdata_reg;
                end
                tail_next[cls_reg] = fs_rdata_reg;
                size_next[cls_reg] = size_reg[cls_reg] + 1'b1;
                res_status_next    = ST_OK;
                res_handle_next    = 6'(fs_rdata_reg);
                res_class_next     = cls_reg;
                res_count_next     = 7'(size_reg[cls_reg] + 1'b1);
                fixn_addr_next     = tail_reg[cls_reg];
                fixn_data_next     = fs_rdata_reg;
                do_fixp_next       = 1'b0;
                if (size_reg[cls_reg] != '0)
                begin
                    do_fixn_next = 1'b1;
                    state_next   = S_FIXN;
                end
                else
                begin
                    do_fixn_next = 1'b0;
                    state_next   = S_REPLY;
                end
            end

            S_EVAL:
            begin
                if (op_reg == REQ_REMOVE && !pool_rd_live)
                begin
                    res_status_next  = ST_BAD_HDL;
                    res_handle_next  = 6'(e_reg);
                    res_address_next = '0;
                    res_payload_next = '0;
                    res_class_next   = CLASS_LOW;
                    res_count_next   = '0;
                    state_next       = S_REPLY;
                end
                else
                begin
                    // Unlink the entry, free it and plan the neighbor rewrites
                    pool_wr.live_we = 1'b1;
                    pool_waddr      = e_reg;
                    pool_wlive      = 1'b0;
                    if (free_top_reg < CW'(POOL_ENTRIES))
                    begin
                        fs_we         = 1'b1;
                        fs_waddr      = IDX_W'(free_top_reg);
                        fs_wdata      = e_reg;
                        free_top_next = free_top_reg + 1'b1;
                    end
                    fixn_addr_next = pool_rd_prev;
                    fixn_data_next = pool_rd_next;
                    fixp_addr_next = pool_rd_next;
                    fixp_data_next = pool_rd_prev;
                    do_fixn_next   = 1'b0;
                    do_fixp_next   = 1'b0;
                    if (head_reg[ev_cls] == e_reg)
                    begin
                        head_next[ev_cls] = pool_rd_next;
                    end
                    else
                    begin
                        do_fixn_next = 1'b1;
                    end
                    if (tail_reg[ev_cls] == e_reg)
                    begin
                        tail_next[ev_cls] = pool_rd_prev;
                    end
                    else
                    begin
                        do_fixp_next = 1'b1;
                    end
                    size_next[ev_cls] = ev_size;
                    if (ev_size == '0)
                    begin
                        head_next[ev_cls] = '0;
                        tail_next[ev_cls] = '0;
                    end
                    res_status_next  = ST_OK;
                    res_handle_next  = 6'(e_reg);
                    res_address_next = pool_rd_address;
                    res_payload_next = pool_rd_payload;
                    res_class_next   = ev_cls;
                    res_count_next   = 7'(ev_size);
                    if (head_reg[ev_cls] != e_reg)
                    begin
                        state_next = S_FIXN;
                    end
                    else if (tail_reg[ev_cls] != e_reg)
                    begin
                        state_next = S_FIXP;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end

            S_FIXN:
            begin
                pool_wr.next_we = 1'b1;
                pool_waddr      = fixn_addr_reg;
                pool_wnext      = fixn_data_reg;
                do_fixn_next    = 1'b0;
                state_next      = do_fixp_reg ? S_FIXP : S_REPLY;
            end

            S_FIXP:
            begin
                pool_wr.prev_we = 1'b1;
                pool_waddr      = fixp_addr_reg;
                pool_wprev      = fixp_data_reg;
                do_fixp_next    = 1'b0;
                state_next      = S_REPLY;
            end

            S_REPLY:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    handle_out_next  = res_handle_reg;
                    address_out_next = res_address_reg;
                    payload_out_next = res_payload_reg;
                    class_out_next   = res_class_reg;
                    count_out_next   = res_count_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            free_top_reg  <= CW'(POOL_ENTRIES);
            do_fixn_reg   <= 1'b0;
            do_fixp_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                size_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            free_top_reg  <= free_top_next;
            do_fixn_reg   <= do_fixn_next;
            do_fixp_reg   <= do_fixp_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            size_reg      <= size_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        cls_reg         <= cls_next;
        addr_reg        <= addr_next;
        pay_reg         <= pay_next;
        e_reg           <= e_next;
        fixn_addr_reg   <= fixn_addr_next;
        fixn_data_reg   <= fixn_data_next;
        fixp_addr_reg   <= fixp_addr_next;
        fixp_data_reg   <= fixp_data_next;
        res_status_reg  <= res_status_next;
        res_handle_reg  <= res_handle_next;
        res_address_reg <= res_address_next;
        res_payload_reg <= res_payload_next;
        res_class_reg   <= res_class_next;
        res_count_reg   <= res_count_next;
        status_reg      <= status_next;
        handle_out_reg  <= handle_out_next;
        address_out_reg <= address_out_next;
        payload_out_reg <= payload_out_next;
        class_out_reg   <= class_out_next;
        count_out_reg   <= count_out_next;
    end

    // Free stack memory
    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            free_mem[fs_waddr] <= fs_wdata;
        end
        if (fs_re)
        begin
            fs_rdata_reg <= free_mem[fs_raddr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_handle  = handle_out_reg;
    assign entry_address = address_out_reg;
    assign entry_payload = payload_out_reg;
    assign entry_class   = class_out_reg;
    assign class_count   = count_out_reg;

`ifndef SYNTHESIS
    // Every entry is either free or counted in exactly one class
    a_pool_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 2)'(free_top_reg) + (CW + 2)'(size_reg[0]) + (CW + 2)'(size_reg[1])
            + (CW + 2)'(size_reg[2]) == (CW + 2)'(POOL_ENTRIES))
        else $error("pool entries not conserved");

    // An empty class keeps its head and tail cleared
    a_empty_class_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (size_reg[0] != '0 || (head_reg[0] == '0 && tail_reg[0] == '0))
        && (size_reg[1] != '0 || (head_reg[1] == '0 && tail_reg[1] == '0))
        && (size_reg[2] != '0 || (head_reg[2] == '0 && tail_reg[2] == '0)))
        else $error("empty class with stale head or tail");

    // A request in work blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted while another is in work");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_three_class_linked_queue_manager.sv =====
// Testbench for the three-class linked queue manager: directed table, random traffic, predictor.
`timescale 1ns / 100ps

module tb_three_class_linked_queue_manager;
    import tclq_pkg::*;

    localparam int         POOL_SIZE  = 64;
    localparam logic [1:0] CLASS_NONE = 2'd3;
    localparam int         MAX_SHOWN  = 10;

    typedef struct packed {
        logic [1:0]  st;
        logic [5:0]  hdl;
        logic [15:0] addr;
        logic [31:0] data;
        logic [1:0]  cls;
        logic [6:0]  cnt;
    } qm_result_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [1:0]  cls;
        logic [15:0] addr;
        logic [31:0] data;
        logic [5:0]  hdl;
        logic        typed_in;
        qm_result_t  want;
    } qm_request_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [1:0]  priority_req;
    logic [15:0] address;
    logic [31:0] payload;
    logic [5:0]  handle;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  entry_handle;
    logic [15:0] entry_address;
    logic [31:0] entry_payload;
    logic [1:0]  entry_class;
    logic [6:0]  class_count;

    // Shadow of the entry pool, free stack and queue registers
    logic [5:0]  pool_next [POOL_SIZE];
    logic [5:0]  pool_prev [POOL_SIZE];
    logic [15:0] pool_addr [POOL_SIZE];
    logic [31:0] pool_data [POOL_SIZE];
    logic [1:0]  pool_class [POOL_SIZE];
    bit          pool_live [POOL_SIZE];
    logic [5:0]  free_stack [POOL_SIZE];
    int          free_count;
    logic [5:0]  class_head [NUM_CLASSES];
    logic [5:0]  class_tail [NUM_CLASSES];
    int          class_size [NUM_CLASSES];

    qm_result_t  expected_results[$];
    qm_request_t directed_rows[$];
    int          mismatch_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          sink_hold_req;

    three_class_linked_queue_manager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .priority_req  (priority_req),
        .address       (address),
        .payload       (payload),
        .handle        (handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .entry_handle  (entry_handle),
        .entry_address (entry_address),
        .entry_payload (entry_payload),
        .entry_class   (entry_class),
        .class_count   (class_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Unlink an in-use entry from its class, push it back on the free stack
    function automatic qm_result_t unlink_pool_entry(int e);
        int         c;
        logic [5:0] nx;
        logic [5:0] pv;
        c  = pool_class[e];
        nx = pool_next[e];
        pv = pool_prev[e];
        if (c >= NUM_CLASSES)
            c = 0;
        if (class_head[c] == e)
            class_head[c] = nx;
        else
            pool_next[pv] = nx;
        if (class_tail[c] == e)
            class_tail[c] = pv;
        else
            pool_prev[nx] = pv;
        if (class_size[c] > 0)
            class_size[c]--;
        if (class_size[c] == 0)
        begin
            class_head[c] = '0;
            class_tail[c] = '0;
        end
        pool_live[e] = 1'b0;
        if (free_count < POOL_SIZE)
        begin
            free_stack[free_count] = e[5:0];
            free_count++;
        end
        return '{ST_OK, e[5:0], pool_addr[e], pool_data[e], c[1:0], class_size[c][6:0]};
    endfunction

    // Work out the result of one request and advance the shadow state
    function automatic qm_result_t predict_queue_result(qm_request_t rq);
        int         c;
        int         e;
        logic [5:0] t;
        c = rq.cls;
        case (rq.req)
            REQ_PUSH:
            begin
                if (c >= NUM_CLASSES)
                    return '{ST_FULL, 6'd0, 16'd0, 32'd0, rq.cls, 7'd0};
                if (free_count == 0)
                    return '{ST_FULL, 6'd0, 16'd0, 32'd0, rq.cls, class_size[c][6:0]};
                free_count--;
                e = free_stack[free_count];
                pool_addr[e]  = rq.addr;
                pool_data[e]  = rq.data;
                pool_class[e] = rq.cls;
                pool_live[e]  = 1'b1;
                pool_next[e]  = '0;
                if (class_size[c] == 0)
                begin
                    pool_prev[e]  = '0;
                    class_head[c] = e[5:0];
                end
                else
                begin
                    t = class_tail[c];
                    pool_prev[e] = t;
                    pool_next[t] = e[5:0];
                end
                class_tail[c] = e[5:0];
                class_size[c]++;
                return '{ST_OK, e[5:0], 16'd0, 32'd0, rq.cls, class_size[c][6:0]};
            end
            REQ_POP:
            begin
                if (c >= NUM_CLASSES || class_size[c] == 0)
                    return '{ST_EMPTY, 6'd0, 16'd0, 32'd0, rq.cls, 7'd0};
                return unlink_pool_entry(class_head[c]);
            end
            REQ_REMOVE:
            begin
                if (!pool_live[rq.hdl])
                    return '{ST_BAD_HDL, rq.hdl, 16'd0, 32'd0, 2'd0, 7'd0};
                return unlink_pool_entry(rq.hdl);
            end
            default:
                return '{ST_OK, 6'd0, 16'd0, 32'd0, 2'd0, 7'd0};
        endcase
    endfunction

    // Offer one request, hold it until accepted, then queue its expected result
    task automatic offer_request(input qm_request_t rq);
        qm_result_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq.req;
        priority_req <= rq.cls;
        address      <= rq.addr;
        payload      <= rq.data;
        handle       <= rq.hdl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = predict_queue_result(rq);
        expected_results.push_back(rq.typed_in ? rq.want : pred);
    endtask

    // Drop the request line and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req > 0)
            begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        qm_result_t got;
        qm_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, entry_handle, entry_address, entry_payload, entry_class,
                    class_count};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("ERROR: unexpected result st=%0d hdl=%0d addr=%h data=%h cls=%0d cnt=%0d",
                             got.st, got.hdl, got.addr, got.data, got.cls, got.cnt);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.st !== exp_r.st || got.hdl !== exp_r.hdl || got.addr !== exp_r.addr ||
                    got.data !== exp_r.data || got.cls !== exp_r.cls || got.cnt !== exp_r.cnt)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                    begin
                        $display("ERROR: expected st=%0d hdl=%0d addr=%h data=%h cls=%0d cnt=%0d",
                                 exp_r.st, exp_r.hdl, exp_r.addr, exp_r.data, exp_r.cls,
                                 exp_r.cnt);
                        $display("       actual   st=%0d hdl=%0d addr=%h data=%h cls=%0d cnt=%0d",
                                 got.st, got.hdl, got.addr, got.data, got.cls, got.cnt);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        qm_request_t rq;
        int          push_w;
        int          pop_w;
        int          r;
        int          start;
        int          src_pct [3];
        int          sink_pct [3];

        src_pct  = '{12, 72, 0};
        sink_pct = '{72, 12, 0};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_NOP;
        priority_req  = CLASS_LOW;
        address       = '0;
        payload       = '0;
        handle        = '0;
        mismatch_count = 0;
        sink_hold_req = 0;
        src_idle_pct  = src_pct[0];
        sink_idle_pct = sink_pct[0];

        // Reset the shadow state: free stack hands out 0, 1, 2, ... first
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_live[i]  = 1'b0;
            free_stack[i] = 6'(POOL_SIZE - 1 - i);
        end
        free_count = POOL_SIZE;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            class_head[c] = '0;
            class_tail[c] = '0;
            class_size[c] = 0;
        end

        // Directed table: refusals on an empty pool, then link and unlink cases
        directed_rows.push_back('{REQ_POP, CLASS_LOW, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1,
                                  '{ST_EMPTY, 6'd0, 16'd0, 32'd0, CLASS_LOW, 7'd0}});
        directed_rows.push_back('{REQ_POP, CLASS_NONE, 16'd0, 32'd0, 6'd0, 1'b1,
                                  '{ST_EMPTY, 6'd0, 16'd0, 32'd0, CLASS_NONE, 7'd0}});
        directed_rows.push_back('{REQ_PUSH, CLASS_NONE, 16'h1234, 32'h5678_9ABC, 6'd0, 1'b1,
                                  '{ST_FULL, 6'd0, 16'd0, 32'd0, CLASS_NONE, 7'd0}});
        directed_rows.push_back('{REQ_REMOVE, CLASS_HIGH, 16'd0, 32'd0, 6'd63, 1'b1,
                                  '{ST_BAD_HDL, 6'd63, 16'd0, 32'd0, 2'd0, 7'd0}});
        directed_rows.push_back('{REQ_NOP, CLASS_NONE, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1,
                                  '{ST_OK, 6'd0, 16'd0, 32'd0, 2'd0, 7'd0}});
        directed_rows.push_back('{REQ_PUSH, CLASS_LOW, 16'h0000, 32'h0000_0000, 6'd0, 1'b1,
                                  '{ST_OK, 6'd0, 16'd0, 32'd0, CLASS_LOW, 7'd1}});
        directed_rows.push_back('{REQ_PUSH, CLASS_LOW, 16'hFFFF, 32'hFFFF_FFFF, 6'd0, 1'b1,
                                  '{ST_OK, 6'd1, 16'd0, 32'd0, CLASS_LOW, 7'd2}});
        directed_rows.push_back('{REQ_PUSH, CLASS_NORMAL, 16'h1234, 32'h0BAD_F00D, 6'd0, 1'b1,
                                  '{ST_OK, 6'd2, 16'd0, 32'd0, CLASS_NORMAL, 7'd1}});
        directed_rows.push_back('{REQ_PUSH, CLASS_HIGH, 16'h8001, 32'h8000_0001, 6'd0, 1'b1,
                                  '{ST_OK, 6'd3, 16'd0, 32'd0, CLASS_HIGH, 7'd1}});
        directed_rows.push_back('{REQ_PUSH, CLASS_LOW, 16'h5555, 32'hAAAA_AAAA, 6'd0, 1'b1,
                                  '{ST_OK, 6'd4, 16'd0, 32'd0, CLASS_LOW, 7'd3}});
        // Middle, tail and only-entry unlinks go through the predictor
        directed_rows.push_back('{REQ_REMOVE, CLASS_LOW, 16'd0, 32'd0, 6'd1, 1'b0, '0});
        directed_rows.push_back('{REQ_REMOVE, CLASS_LOW, 16'd0, 32'd0, 6'd4, 1'b0, '0});
        directed_rows.push_back('{REQ_POP, CLASS_LOW, 16'd0, 32'd0, 6'd0, 1'b0, '0});
        directed_rows.push_back('{REQ_POP, CLASS_LOW, 16'd0, 32'd0, 6'd0, 1'b1,
                                  '{ST_EMPTY, 6'd0, 16'd0, 32'd0, CLASS_LOW, 7'd0}});
        directed_rows.push_back('{REQ_REMOVE, CLASS_NORMAL, 16'd0, 32'd0, 6'd2, 1'b0, '0});
        directed_rows.push_back('{REQ_REMOVE, CLASS_NORMAL, 16'd0, 32'd0, 6'd2, 1'b1,
                                  '{ST_BAD_HDL, 6'd2, 16'd0, 32'd0, 2'd0, 7'd0}});
        directed_rows.push_back('{REQ_PUSH, CLASS_HIGH, 16'hAAAA, 32'h5555_5555, 6'd0, 1'b0,
                                  '0});
        directed_rows.push_back('{REQ_PUSH, CLASS_HIGH, 16'h7FFE, 32'h7FFF_FFFE, 6'd0, 1'b0,
                                  '0});
        directed_rows.push_back('{REQ_REMOVE, CLASS_HIGH, 16'd0, 32'd0, 6'd3, 1'b0, '0});
        directed_rows.push_back('{REQ_POP, CLASS_HIGH, 16'd0, 32'd0, 6'd0, 1'b0, '0});
        directed_rows.push_back('{REQ_POP, CLASS_NORMAL, 16'd0, 32'd0, 6'd0, 1'b1,
                                  '{ST_EMPTY, 6'd0, 16'd0, 32'd0, CLASS_NORMAL, 7'd0}});
        directed_rows.push_back('{REQ_POP, CLASS_HIGH, 16'd0, 32'd0, 6'd0, 1'b0, '0});
        directed_rows.push_back('{REQ_REMOVE, CLASS_LOW, 16'd0, 32'd0, 6'd42, 1'b1,
                                  '{ST_BAD_HDL, 6'd42, 16'd0, 32'd0, 2'd0, 7'd0}});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i]);

        // Hold off the receiver while pushes fill the pool and overflow it
        sink_hold_req = 300;
        while (free_count > 0)
        begin
            rq = '{REQ_PUSH, 2'($urandom_range(2)), 16'($urandom), $urandom, 6'($urandom),
                   1'b0, '0};
            offer_request(rq);
        end
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            rq = '{REQ_PUSH, 2'(c), 16'($urandom), $urandom, 6'($urandom), 1'b0, '0};
            offer_request(rq);
        end
        drain_results();

        // Random traffic in three idling phases, in randomly chosen fill and drain episodes
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct  = src_pct[ph];
            sink_idle_pct = sink_pct[ph];
            for (int n = 0; n < 400; n++)
            begin
                if (n % 100 == 0)
                begin
                    case ($urandom_range(2))
                        0:       push_w = 80;
                        1:       push_w = 25;
                        default: push_w = 50;
                    endcase
                    pop_w = (100 - push_w - 6) / 2;
                end
                rq = '{REQ_NOP, 2'($urandom_range(2)), 16'($urandom), $urandom, 6'($urandom),
                       1'b0, '0};
                if ($urandom_range(99) < 6)
                    rq.cls = CLASS_NONE;
                r = $urandom_range(99);
                if (r < push_w)
                    rq.req = REQ_PUSH;
                else if (r < push_w + pop_w)
                    rq.req = REQ_POP;
                else if (r < 94)
                begin
                    rq.req = REQ_REMOVE;
                    // Mostly aim at a live entry
                    if ($urandom_range(99) < 80)
                    begin
                        start = $urandom_range(POOL_SIZE - 1);
                        for (int k = 0; k < POOL_SIZE; k++)
                        begin
                            if (pool_live[(start + k) % POOL_SIZE])
                            begin
                                rq.hdl = 6'((start + k) % POOL_SIZE);
                                break;
                            end
                        end
                    end
                end
                else
                    rq.req = REQ_NOP;
                offer_request(rq);
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
